/* rtl/hbar_pkg.sv */
// Package for the bus address router: target codes, I/O register offsets,
// item, result, state and update types shared by all router files.
// No dependencies.
`default_nettype none

package hbar_pkg;

  // Target store of a decoded access
  typedef enum logic [3:0] {
    TgtNone   = 4'd0,
    TgtBoot   = 4'd1,
    TgtCart   = 4'd2,
    TgtVram   = 4'd3,
    TgtWram   = 4'd4,
    TgtOam    = 4'd5,
    TgtUnused = 4'd6,
    TgtIo     = 4'd7,
    TgtHram   = 4'd8,
    TgtIe     = 4'd9,
    TgtOther  = 4'd10,
    TgtFixed  = 4'd11
  } tgt_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgColorMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRunBootRom = 2'd1;

  // Field widths
  localparam int unsigned AddrW  = 16;
  localparam int unsigned DataW  = 8;
  localparam int unsigned IndexW = 15;
  localparam int unsigned BankW  = 3;

  // Memory map boundaries
  localparam logic [AddrW-1:0] AddrVramBase   = 16'h8000;
  localparam logic [AddrW-1:0] AddrVramLast   = 16'h9FFF;
  localparam logic [AddrW-1:0] AddrExtRamBase = 16'hA000;
  localparam logic [AddrW-1:0] AddrExtRamLast = 16'hBFFF;
  localparam logic [AddrW-1:0] AddrEchoLast   = 16'hFDFF;
  localparam logic [AddrW-1:0] AddrOamLast    = 16'hFE9F;
  localparam logic [AddrW-1:0] AddrUnusedLow  = 16'hFEBF;
  localparam logic [AddrW-1:0] AddrUnusedLast = 16'hFEFF;
  localparam logic [AddrW-1:0] AddrIoBase     = 16'hFF00;
  localparam logic [AddrW-1:0] AddrIoLast     = 16'hFF7F;
  localparam logic [AddrW-1:0] AddrHramLast   = 16'hFFFE;
  localparam logic [AddrW-1:0] AddrBootLow    = 16'h00FF;
  localparam logic [AddrW-1:0] AddrBootHiBase = 16'h0200;
  localparam logic [AddrW-1:0] AddrBootHiLast = 16'h08FF;
  localparam logic [DataW-1:0] UnusedBase     = 8'hA0;

  // I/O register offsets from 0xFF00
  localparam logic [6:0] IoJoyp  = 7'h00;
  localparam logic [6:0] IoSc    = 7'h02;
  localparam logic [6:0] IoDiv   = 7'h04;
  localparam logic [6:0] IoTac   = 7'h07;
  localparam logic [6:0] IoIf    = 7'h0F;
  localparam logic [6:0] IoSnd10 = 7'h10;
  localparam logic [6:0] IoSnd11 = 7'h11;
  localparam logic [6:0] IoSnd12 = 7'h12;
  localparam logic [6:0] IoSnd13 = 7'h13;
  localparam logic [6:0] IoSnd14 = 7'h14;
  localparam logic [6:0] IoSnd15 = 7'h15;
  localparam logic [6:0] IoSnd16 = 7'h16;
  localparam logic [6:0] IoSnd17 = 7'h17;
  localparam logic [6:0] IoSnd18 = 7'h18;
  localparam logic [6:0] IoSnd19 = 7'h19;
  localparam logic [6:0] IoSnd1A = 7'h1A;
  localparam logic [6:0] IoSnd1B = 7'h1B;
  localparam logic [6:0] IoSnd1C = 7'h1C;
  localparam logic [6:0] IoSnd1D = 7'h1D;
  localparam logic [6:0] IoSnd1E = 7'h1E;
  localparam logic [6:0] IoSnd1F = 7'h1F;
  localparam logic [6:0] IoSnd20 = 7'h20;
  localparam logic [6:0] IoSnd21 = 7'h21;
  localparam logic [6:0] IoSnd22 = 7'h22;
  localparam logic [6:0] IoSnd23 = 7'h23;
  localparam logic [6:0] IoSnd24 = 7'h24;
  localparam logic [6:0] IoSnd25 = 7'h25;
  localparam logic [6:0] IoSnd26 = 7'h26;
  localparam logic [6:0] IoSndGapBase = 7'h27;
  localparam logic [6:0] IoSndGapLast = 7'h2F;
  localparam logic [6:0] IoWaveBase   = 7'h30;
  localparam logic [6:0] IoWaveLast   = 7'h3F;
  localparam logic [6:0] IoLcdc  = 7'h40;
  localparam logic [6:0] IoStat  = 7'h41;
  localparam logic [6:0] IoLy    = 7'h44;
  localparam logic [6:0] IoLyc   = 7'h45;
  localparam logic [6:0] IoDma   = 7'h46;
  localparam logic [6:0] IoWy    = 7'h4A;
  localparam logic [6:0] IoKey1  = 7'h4D;
  localparam logic [6:0] IoVbk   = 7'h4F;
  localparam logic [6:0] IoBoot  = 7'h50;
  localparam logic [6:0] IoHdma1 = 7'h51;
  localparam logic [6:0] IoHdma2 = 7'h52;
  localparam logic [6:0] IoHdma3 = 7'h53;
  localparam logic [6:0] IoHdma4 = 7'h54;
  localparam logic [6:0] IoHdma5 = 7'h55;
  localparam logic [6:0] IoRp    = 7'h56;
  localparam logic [6:0] IoBcpd  = 7'h69;
  localparam logic [6:0] IoOcpd  = 7'h6B;
  localparam logic [6:0] IoOpri  = 7'h6C;
  localparam logic [6:0] IoSvbk  = 7'h70;

  // LCD mode in which video memory is locked
  localparam logic [1:0] LcdModeXfer = 2'd3;

  // One bus access
  typedef struct packed {
    logic             action;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
    logic             from_video;
    logic             from_audio;
    logic [1:0]       screen_mode;
    logic             audio_on;
  } item_t;

  // One routing result
  typedef struct packed {
    tgt_e              target;
    logic [IndexW-1:0] store_index;
    logic              store_write;
    logic [DataW-1:0]  write_mask;
    logic [DataW-1:0]  read_force_ones;
    logic [DataW-1:0]  fixed_value;
    logic              mirror_four;
  } res_t;

  // Bank and overlay state seen by the decoder
  typedef struct packed {
    logic             color_mode;
    logic             video_bank;
    logic [BankW-1:0] work_bank;
    logic             boot_overlay_on;
  } state_t;

  // State updates requested by a decoded write
  typedef struct packed {
    logic             video_bank_we;
    logic             video_bank;
    logic             work_bank_we;
    logic [BankW-1:0] work_bank;
    logic             boot_clear;
  } upd_t;

endpackage

`default_nettype wire

/* rtl/hbar_if.sv */
// Channel interfaces of the bus address router: access input, route output
// and configuration write. Depends on hbar_pkg.
`default_nettype none

interface hbar_in_if;
  import hbar_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [AddrW-1:0]     address;
  logic [DataW-1:0]     write_data;
  logic                 from_video;
  logic                 from_audio;
  logic [1:0]           screen_mode;
  logic                 audio_on;

  modport source (output valid, action, address, write_data, from_video, from_audio,
                  screen_mode, audio_on, input ready);
  modport sink (input valid, action, address, write_data, from_video, from_audio,
                screen_mode, audio_on, output ready);
endinterface

interface hbar_out_if;
  import hbar_pkg::*;
  logic              valid;
  logic              ready;
  tgt_e              target;
  logic [IndexW-1:0] store_index;
  logic              store_write;
  logic [DataW-1:0]  write_mask;
  logic [DataW-1:0]  read_force_ones;
  logic [DataW-1:0]  fixed_value;
  logic              mirror_four;

  modport source (output valid, target, store_index, store_write, write_mask,
                  read_force_ones, fixed_value, mirror_four, input ready);
  modport sink (input valid, target, store_index, store_write, write_mask,
                read_force_ones, fixed_value, mirror_four, output ready);
endinterface

interface hbar_cfg_if;
  import hbar_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic               data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/handheld_bus_address_router.sv */
// Bus address router top level: input register, decoder, result register.
// An accepted item is held in the input register and its decoded result is then loaded
// into the result register. Throughput: one item per cycle while out_o is ready, set by the
// single decode stage. Reset clears both valid flags, sets work bank 1, video bank 0,
// color mode 0 and maps the boot overlay. Depends on hbar_pkg, hbar_if, hbar_state,
// hbar_decode.
`default_nettype none

module handheld_bus_address_router (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hbar_in_if.sink    in_i,
  hbar_out_if.source out_o,
  hbar_cfg_if.sink   cfg_i
);
  import hbar_pkg::*;

  logic   in_valid_q;
  item_t  in_item_q;
  logic   out_valid_q;
  res_t   out_res_q;
  logic   advance;
  logic   accept;
  logic   fire;
  logic   cfg_we;
  res_t   res_d;
  upd_t   upd;
  state_t state;

  // Pipeline handshake: the result register frees the input register
  assign advance   = ~out_valid_q | out_o.ready;
  assign fire      = in_valid_q & advance;
  assign in_i.ready = ~in_valid_q | advance;
  assign accept    = in_i.valid & in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_we    = cfg_i.valid;

  // Hold the accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q.action      <= in_i.action;
      in_item_q.address     <= in_i.address;
      in_item_q.write_data  <= in_i.write_data;
      in_item_q.from_video  <= in_i.from_video;
      in_item_q.from_audio  <= in_i.from_audio;
      in_item_q.screen_mode <= in_i.screen_mode;
      in_item_q.audio_on    <= in_i.audio_on;
    end
  end

  hbar_decode u_decode (
    .item_i  (in_item_q),
    .state_i (state),
    .res_o   (res_d),
    .upd_o   (upd)
  );

  hbar_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .upd_en_i    (fire),
    .upd_i       (upd),
    .state_o     (state)
  );

  // Advance the decoded item into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.target          = out_res_q.target;
  assign out_o.store_index     = out_res_q.store_index;
  assign out_o.store_write     = out_res_q.store_write;
  assign out_o.write_mask      = out_res_q.write_mask;
  assign out_o.read_force_ones = out_res_q.read_force_ones;
  assign out_o.fixed_value     = out_res_q.fixed_value;
  assign out_o.mirror_four     = out_res_q.mirror_four;

endmodule

`default_nettype wire

/* rtl/hbar_state.sv */
// Configuration registers and bank/overlay state of the bus address router.
// Depends on hbar_pkg.
`default_nettype none

module hbar_state (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [hbar_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic                        cfg_data_i,
  input  wire logic                        upd_en_i,
  input  wire hbar_pkg::upd_t              upd_i,
  output      hbar_pkg::state_t            state_o
);
  import hbar_pkg::*;

  logic             color_mode_q;
  logic             run_boot_rom_q;
  logic             video_bank_q;
  logic [BankW-1:0] work_bank_q;
  logic             boot_overlay_q;

  // Load configuration; a run_boot_rom write also reloads the overlay flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q   <= 1'b0;
      run_boot_rom_q <= 1'b1;
      video_bank_q   <= 1'b0;
      work_bank_q    <= BankW'(1);
      boot_overlay_q <= 1'b1;
    end else begin
      if (cfg_we_i && cfg_index_i == CfgColorMode) begin
        color_mode_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == CfgRunBootRom) begin
        run_boot_rom_q <= cfg_data_i;
        boot_overlay_q <= cfg_data_i;
      end else if (upd_en_i && upd_i.boot_clear) begin
        boot_overlay_q <= 1'b0;
      end
      // Take bank register writes from the decoded item
      if (upd_en_i && upd_i.video_bank_we) begin
        video_bank_q <= upd_i.video_bank;
      end
      if (upd_en_i && upd_i.work_bank_we) begin
        work_bank_q <= upd_i.work_bank;
      end
    end
  end

  assign state_o.color_mode      = color_mode_q;
  assign state_o.video_bank      = video_bank_q;
  assign state_o.work_bank       = work_bank_q;
  assign state_o.boot_overlay_on = boot_overlay_q & (run_boot_rom_q | ~run_boot_rom_q);

endmodule

`default_nettype wire

/* rtl/hbar_decode.sv */
// Address decoder of the bus address router: maps one access to a target
// store, index, masks and state updates. Depends on hbar_pkg.
`default_nettype none

module hbar_decode (
  input  wire hbar_pkg::item_t  item_i,
  input  wire hbar_pkg::state_t state_i,
  output      hbar_pkg::res_t   res_o,
  output      hbar_pkg::upd_t   upd_o
);
  import hbar_pkg::*;

  logic [AddrW-1:0]  a;
  logic [6:0]        off;
  logic [IndexW-1:0] io_idx;
  logic [IndexW-1:0] vram_idx;
  logic [IndexW-1:0] wram_idx;
  logic [IndexW-1:0] unused_idx;
  logic              vram_open;
  logic              oam_open;
  logic              mode_xfer;
  logic              in_wave;
  logic              in_gap;
  logic [BankW-1:0]  new_bank;

  assign a         = item_i.address;
  assign off       = a[6:0];
  assign io_idx    = {8'd0, off};
  assign vram_idx  = {1'b0, state_i.video_bank, a[12:0]};
  // Echo shares the low 13 address bits with work RAM
  assign wram_idx  = a[12] ? {state_i.work_bank, a[11:0]} : {3'd0, a[11:0]};
  assign unused_idx = {7'd0, a[7:0] - UnusedBase};
  assign mode_xfer = item_i.screen_mode == LcdModeXfer;
  assign vram_open = item_i.from_video | ~mode_xfer;
  assign oam_open  = item_i.from_video | ~item_i.screen_mode[1];
  assign in_wave   = off >= IoWaveBase && off <= IoWaveLast;
  assign in_gap    = off >= IoSndGapBase && off <= IoSndGapLast;
  assign new_bank  = (item_i.write_data[2:0] != 3'd0) ? item_i.write_data[2:0] : BankW'(1);

  always_comb begin
    res_o = '0;
    upd_o = '0;
    if (!item_i.action) begin
      // Read path
      if (a < AddrVramBase) begin
        res_o.store_index = a[14:0];
        if (state_i.boot_overlay_on && (a <= AddrBootLow ||
            (state_i.color_mode && a >= AddrBootHiBase && a <= AddrBootHiLast))) begin
          res_o.target = TgtBoot;
        end else begin
          res_o.target = TgtCart;
        end
      end else if (a <= AddrVramLast) begin
        if (vram_open) begin
          res_o.target      = TgtVram;
          res_o.store_index = vram_idx;
        end else begin
          res_o.target      = TgtFixed;
          res_o.fixed_value = 8'hFF;
        end
      end else if (a <= AddrExtRamLast) begin
        res_o.target      = TgtCart;
        res_o.store_index = a[14:0];
      end else if (a <= AddrEchoLast) begin
        res_o.target      = TgtWram;
        res_o.store_index = wram_idx;
      end else if (a <= AddrOamLast) begin
        if (oam_open) begin
          res_o.target      = TgtOam;
          res_o.store_index = {7'd0, a[7:0]};
        end else begin
          res_o.target      = TgtFixed;
          res_o.fixed_value = 8'hFF;
        end
      end else if (a <= AddrUnusedLast) begin
        if (!state_i.color_mode) begin
          res_o.target = TgtFixed;
        end else if (mode_xfer) begin
          res_o.target      = TgtFixed;
          res_o.fixed_value = 8'hFF;
        end else begin
          res_o.target      = TgtUnused;
          res_o.store_index = unused_idx;
        end
      end else if (a <= AddrIoLast) begin
        // I/O read: stored register unless a special case applies
        res_o.target      = TgtIo;
        res_o.store_index = io_idx;
        case (off)
          IoIf:    res_o.read_force_ones = 8'hE0;
          IoSnd10: res_o.read_force_ones = 8'h80;
          IoSnd11, IoSnd16: res_o.read_force_ones = 8'h3F;
          IoSnd14, IoSnd19, IoSnd1E, IoSnd23: res_o.read_force_ones = 8'hBF;
          IoSnd1A: res_o.read_force_ones = 8'h7F;
          IoSnd1C: res_o.read_force_ones = 8'h9F;
          IoSnd26: res_o.read_force_ones = 8'h70;
          IoStat:  res_o.read_force_ones = 8'h80;
          IoSnd13, IoSnd15, IoSnd18, IoSnd1B, IoSnd1D, IoSnd1F, IoSnd20,
          IoHdma1, IoHdma2, IoHdma3, IoHdma4, IoRp: begin
            res_o.target      = TgtFixed;
            res_o.store_index = '0;
            res_o.fixed_value = 8'hFF;
          end
          IoKey1: begin
            if (state_i.color_mode) begin
              res_o.read_force_ones = 8'h7E;
            end else begin
              res_o.target      = TgtFixed;
              res_o.store_index = '0;
              res_o.fixed_value = 8'hFF;
            end
          end
          IoVbk: begin
            res_o.target      = TgtFixed;
            res_o.store_index = '0;
            res_o.fixed_value = state_i.color_mode ? {7'h7F, state_i.video_bank} : 8'hFF;
          end
          IoHdma5: begin
            if (state_i.color_mode) begin
              res_o.target = TgtOther;
            end else begin
              res_o.target      = TgtFixed;
              res_o.store_index = '0;
              res_o.fixed_value = 8'hFF;
            end
          end
          IoBcpd, IoOcpd: begin
            if (state_i.color_mode && !mode_xfer) begin
              res_o.target = TgtOther;
            end else begin
              res_o.target      = TgtFixed;
              res_o.store_index = '0;
              res_o.fixed_value = 8'hFF;
            end
          end
          IoSvbk: begin
            if (state_i.color_mode) begin
              res_o.read_force_ones = 8'hF8;
            end else begin
              res_o.target      = TgtFixed;
              res_o.store_index = '0;
              res_o.fixed_value = 8'hFF;
            end
          end
          default: begin
            if (in_gap) begin
              res_o.target      = TgtFixed;
              res_o.store_index = '0;
              res_o.fixed_value = 8'hFF;
            end else if (in_wave && !item_i.from_audio) begin
              res_o.target = TgtOther;
            end
          end
        endcase
      end else if (a <= AddrHramLast) begin
        res_o.target      = TgtHram;
        res_o.store_index = io_idx;
      end else begin
        res_o.target = TgtIe;
      end
    end else if (a >= AddrIoBase && a <= AddrIoLast) begin
      // I/O write
      case (off)
        IoJoyp, IoSc, IoDiv, IoTac, IoSnd20, IoSnd26, IoLcdc, IoStat, IoLy, IoLyc,
        IoDma, IoWy, IoOpri: begin
          res_o.target      = TgtOther;
          res_o.store_index = io_idx;
        end
        IoSnd10, IoSnd11, IoSnd12, IoSnd13, IoSnd14, IoSnd16, IoSnd17, IoSnd18,
        IoSnd19, IoSnd1A, IoSnd1B, IoSnd1C, IoSnd1D, IoSnd1E, IoSnd21, IoSnd22,
        IoSnd23, IoSnd24, IoSnd25: begin
          if (item_i.audio_on) begin
            res_o.target      = TgtOther;
            res_o.store_index = io_idx;
          end
        end
        IoKey1: begin
          if (state_i.color_mode) begin
            res_o.target      = TgtIo;
            res_o.store_index = io_idx;
            res_o.store_write = 1'b1;
            res_o.write_mask  = 8'h01;
          end
        end
        IoVbk: begin
          if (state_i.color_mode) begin
            res_o.target        = TgtIo;
            res_o.store_index   = io_idx;
            res_o.store_write   = 1'b1;
            res_o.write_mask    = 8'hFF;
            upd_o.video_bank_we = 1'b1;
            upd_o.video_bank    = item_i.write_data[0];
          end
        end
        IoBoot: upd_o.boot_clear = 1'b1;
        IoHdma1: begin
          res_o.target      = TgtIo;
          res_o.store_index = io_idx;
          res_o.store_write = 1'b1;
          res_o.write_mask  = 8'hFF;
        end
        IoHdma2, IoHdma4: begin
          res_o.target      = TgtIo;
          res_o.store_index = io_idx;
          res_o.store_write = 1'b1;
          res_o.write_mask  = 8'hF0;
        end
        IoHdma3: begin
          res_o.target      = TgtIo;
          res_o.store_index = io_idx;
          res_o.store_write = 1'b1;
          res_o.write_mask  = 8'h1F;
        end
        IoHdma5, IoBcpd, IoOcpd: begin
          if (state_i.color_mode) begin
            res_o.target      = TgtOther;
            res_o.store_index = io_idx;
          end
        end
        IoSvbk: begin
          if (state_i.color_mode) begin
            res_o.target       = TgtIo;
            res_o.store_index  = io_idx;
            res_o.store_write  = 1'b1;
            res_o.write_mask   = 8'hFF;
            upd_o.work_bank_we = 1'b1;
            upd_o.work_bank    = new_bank;
          end
        end
        default: begin
          res_o.store_index = io_idx;
          if (in_wave && !item_i.from_audio) begin
            res_o.target = TgtOther;
          end else begin
            res_o.target      = TgtIo;
            res_o.store_write = 1'b1;
            res_o.write_mask  = 8'hFF;
          end
        end
      endcase
    end else begin
      // Memory write: full byte unless the region is locked or unavailable
      res_o.store_write = 1'b1;
      res_o.write_mask  = 8'hFF;
      if (a < AddrVramBase || (a >= AddrExtRamBase && a <= AddrExtRamLast)) begin
        res_o.target      = TgtCart;
        res_o.store_index = a[14:0];
      end else if (a <= AddrVramLast) begin
        if (vram_open) begin
          res_o.target      = TgtVram;
          res_o.store_index = vram_idx;
        end else begin
          res_o = '0;
        end
      end else if (a <= AddrEchoLast) begin
        res_o.target      = TgtWram;
        res_o.store_index = wram_idx;
      end else if (a <= AddrOamLast) begin
        if (oam_open) begin
          res_o.target      = TgtOam;
          res_o.store_index = {7'd0, a[7:0]};
        end else begin
          res_o = '0;
        end
      end else if (a <= AddrUnusedLast) begin
        if (!state_i.color_mode || mode_xfer) begin
          res_o = '0;
        end else if (a <= AddrUnusedLow) begin
          res_o.target      = TgtUnused;
          res_o.store_index = unused_idx;
        end else begin
          res_o.target      = TgtUnused;
          res_o.store_index = {11'h002, a[3:0]};
          res_o.mirror_four = 1'b1;
        end
      end else if (a <= AddrHramLast) begin
        res_o.target      = TgtHram;
        res_o.store_index = io_idx;
      end else begin
        res_o.target = TgtIe;
      end
    end
  end

endmodule

`default_nettype wire
